FILE: hdl/sorted_alarm_timer_queue_macros.svh
// Assertion macros shared by the checker of the sorted alarm timer queue.
// No dependencies; included by files that hold concurrent assertions.
`ifndef SORTED_ALARM_TIMER_QUEUE_MACROS_SVH
`define SORTED_ALARM_TIMER_QUEUE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SATQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted alarm timer queue: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SATQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted alarm timer queue: next-cycle check failed");

`endif

FILE: hdl/satq_pkg.sv
// Package of the sorted alarm timer queue: widths, codes, entry and result types.
// No dependencies; used by every other file except the assertion macros.
package satq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_OUT         = 16;
    localparam int CNT_W           = $clog2(MAX_OUT + 1);

    localparam int TIME_W  = 48;
    localparam int PID_W   = 16;
    localparam int QD_W    = 16;
    localparam int PAY_W   = 16;
    localparam int IDENT_W = 32;
    localparam int KIND_W  = 3;

    localparam logic OP_SCHED = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ID   = 3'd0,
        KIND_WAKE = 3'd1,
        KIND_MSG  = 3'd2,
        KIND_NONE = 3'd3,
        KIND_FULL = 3'd4
    } t_kind;

    // Flag bit 0 is sleep, bit 1 is message.
    typedef struct packed {
        logic [TIME_W-1:0]  time_value;
        logic [PID_W-1:0]   process_id;
        logic [1:0]         flags;
        logic [QD_W-1:0]    queue_descriptor;
        logic [PAY_W-1:0]   payload_handle;
    } t_item;

    typedef struct packed {
        logic [TIME_W-1:0]  due;
        logic [PID_W-1:0]   owner;
        logic [1:0]         flags;
        logic [QD_W-1:0]    queue;
        logic [PAY_W-1:0]   payload;
        logic [IDENT_W-1:0] ident;
    } t_entry;

    typedef struct packed {
        t_kind              kind;
        logic [IDENT_W-1:0] alarm_id;
        logic [PID_W-1:0]   owner_id;
        logic [QD_W-1:0]    target_queue;
        logic [PAY_W-1:0]   payload_out;
        logic               last;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the accepted request
        logic insert;   // sorted insert and id result
        logic reject;   // queue-full result
        logic pop;      // drop the front entry
        logic take;     // front entry becomes the held result
        logic finish;   // emit held result as last, or a none result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic front_due;
        logic front_silent;
        logic pend_valid;
        logic out_free;
    } t_sts;

endpackage

FILE: hdl/satq_in_if.sv
// Request channel of the sorted alarm timer queue: valid, ready and item fields.
// Depends on satq_pkg for field widths.
interface satq_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [satq_pkg::TIME_W-1:0]   time_value;
    logic [satq_pkg::PID_W-1:0]    process_id;
    logic                          is_sleep;
    logic                          has_message;
    logic [satq_pkg::QD_W-1:0]     queue_descriptor;
    logic [satq_pkg::PAY_W-1:0]    payload_handle;

    modport source (
        output valid, op, time_value, process_id, is_sleep, has_message,
               queue_descriptor, payload_handle,
        input  ready
    );
    modport sink (
        input  valid, op, time_value, process_id, is_sleep, has_message,
               queue_descriptor, payload_handle,
        output ready
    );
endinterface

FILE: hdl/satq_out_if.sv
// Result channel of the sorted alarm timer queue: valid, ready and result fields.
// Depends on satq_pkg for field widths.
interface satq_out_if;
    logic                          valid;
    logic                          ready;
    logic [satq_pkg::KIND_W-1:0]   kind;
    logic [satq_pkg::IDENT_W-1:0]  alarm_id;
    logic [satq_pkg::PID_W-1:0]    owner_id;
    logic [satq_pkg::QD_W-1:0]     target_queue;
    logic [satq_pkg::PAY_W-1:0]    payload_out;
    logic                          last;

    modport source (
        output valid, kind, alarm_id, owner_id, target_queue, payload_out, last,
        input  ready
    );
    modport sink (
        input  valid, kind, alarm_id, owner_id, target_queue, payload_out, last,
        output ready
    );
endinterface

FILE: hdl/satq_ctrl.sv
// Controller of the sorted alarm timer queue: accepts requests and sequences
// schedule and tick work. Depends on satq_pkg for the command and status types.
module satq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_op,
    output logic             o_in_ready,
    input  satq_pkg::t_sts   i_sts,
    output satq_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCHED = 3'b010,
        S_TICK  = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_in_op == satq_pkg::OP_TICK) ? S_TICK : S_SCHED;
                end
            end
            S_SCHED: begin
                if (i_sts.out_free) begin
                    o_cmd.reject = i_sts.full;
                    o_cmd.insert = !i_sts.full;
                    n_state      = S_IDLE;
                end
            end
            S_TICK: begin
                if (i_sts.front_due) begin
                    // A silent alarm leaves without a result; otherwise the
                    // held result must be able to move on first.
                    if (i_sts.front_silent) begin
                        o_cmd.pop = 1'b1;
                    end else if (!i_sts.pend_valid || i_sts.out_free) begin
                        o_cmd.pop  = 1'b1;
                        o_cmd.take = 1'b1;
                    end
                end else if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/satq_dp.sv
// Datapath of the sorted alarm timer queue: sorted shift chain of entries,
// held result, output register and counters. Depends on satq_pkg.
module satq_dp #(
    parameter int QUEUE_DEPTH = satq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  satq_pkg::t_cmd    i_cmd,
    output satq_pkg::t_sts    o_sts,
    input  satq_pkg::t_item   i_item,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output satq_pkg::t_result o_out
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    satq_pkg::t_entry r_ent [QUEUE_DEPTH];
    satq_pkg::t_entry n_ent [QUEUE_DEPTH];
    satq_pkg::t_entry new_ent;
    satq_pkg::t_item  r_item;
    satq_pkg::t_result r_pend, n_pend;
    satq_pkg::t_result r_out, n_out;
    logic                               r_out_valid, n_out_valid;
    logic [OCC_W-1:0]                   r_occ, n_occ;
    logic [satq_pkg::IDENT_W-1:0]       r_next_id, n_next_id;
    logic [satq_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic [QUEUE_DEPTH-1:0]             lt;
    logic                               out_free;

    assign out_free = !r_out_valid || i_out_ready;

    assign new_ent.due     = r_item.time_value;
    assign new_ent.owner   = r_item.process_id;
    assign new_ent.flags   = r_item.flags;
    assign new_ent.queue   = r_item.queue_descriptor;
    assign new_ent.payload = r_item.payload_handle;
    assign new_ent.ident   = r_next_id;

    // Each valid entry compares against the new alarm at once; the new
    // alarm goes in front of the first entry it sorts before.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            lt[i] = (OCC_W'(i) < r_occ) &&
                    ((r_item.time_value < r_ent[i].due) ||
                     ((r_item.time_value == r_ent[i].due) &&
                      (r_item.process_id < r_ent[i].owner)));
        end
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_ent[i] = r_ent[i];
        end
        if (i_cmd.insert) begin
            if (lt[0] || (r_occ == '0)) begin
                n_ent[0] = new_ent;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
                if (lt[i-1]) begin
                    n_ent[i] = r_ent[i-1];
                end else if (lt[i] || (OCC_W'(i) == r_occ)) begin
                    n_ent[i] = new_ent;
                end
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                n_ent[i] = r_ent[i+1];
            end
        end
    end

    always_comb begin
        n_occ       = r_occ;
        n_next_id   = r_next_id;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        if (i_cmd.load) begin
            n_cnt = '0;
        end
        if (i_cmd.insert) begin
            n_occ     = r_occ + OCC_W'(1);
            n_next_id = r_next_id + satq_pkg::IDENT_W'(1);
        end
        if (i_cmd.pop) begin
            n_occ = r_occ - OCC_W'(1);
        end

        if (i_cmd.take) begin
            n_cnt                = r_cnt + satq_pkg::CNT_W'(1);
            n_pend.alarm_id      = r_ent[0].ident;
            n_pend.owner_id      = r_ent[0].owner;
            n_pend.last          = 1'b0;
            if (r_ent[0].flags[0]) begin
                n_pend.kind         = satq_pkg::KIND_WAKE;
                n_pend.target_queue = '0;
                n_pend.payload_out  = '0;
            end else begin
                n_pend.kind         = satq_pkg::KIND_MSG;
                n_pend.target_queue = r_ent[0].queue;
                n_pend.payload_out  = r_ent[0].payload;
            end
        end

        priority if (i_cmd.insert) begin
            n_out             = '0;
            n_out.kind        = satq_pkg::KIND_ID;
            n_out.alarm_id    = r_next_id;
            n_out.last        = 1'b1;
            n_out_valid       = 1'b1;
        end else if (i_cmd.reject) begin
            n_out             = '0;
            n_out.kind        = satq_pkg::KIND_FULL;
            n_out.last        = 1'b1;
            n_out_valid       = 1'b1;
        end else if (i_cmd.take && (r_cnt != '0)) begin
            n_out             = r_pend;
            n_out_valid       = 1'b1;
        end else if (i_cmd.finish) begin
            if (r_cnt != '0) begin
                n_out         = r_pend;
            end else begin
                n_out         = '0;
                n_out.kind    = satq_pkg::KIND_NONE;
            end
            n_out.last        = 1'b1;
            n_out_valid       = 1'b1;
        end else begin
            n_out             = r_out;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_ent[i] <= n_ent[i];
        end
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_next_id   <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_occ       <= n_occ;
            r_next_id   <= n_next_id;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_sts.full         = (r_occ == OCC_W'(QUEUE_DEPTH));
    assign o_sts.front_due    = (r_occ != '0) &&
                                (r_ent[0].due <= r_item.time_value) &&
                                (r_cnt < satq_pkg::CNT_W'(satq_pkg::MAX_OUT));
    assign o_sts.front_silent = (r_ent[0].flags == 2'b00);
    assign o_sts.pend_valid   = (r_cnt != '0);
    assign o_sts.out_free     = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: hdl/sorted_alarm_timer_queue.sv
// Sorted alarm timer queue, top level.
// Depends on satq_pkg, satq_in_if, satq_out_if, satq_ctrl and satq_dp.
//
// Requests arrive on i_req. A schedule request (op 0) carries a due time,
// the owning process id, the sleep and message flags, a queue descriptor and
// a payload handle. It is inserted in due-time order, ties broken by process
// id and then by arrival, and answered with one result that carries the new
// alarm id. A full queue answers with a rejected result and uses no id.
// A tick request (op 1) carries the current time. Every alarm whose due time
// is at or before it leaves the front of the queue, earliest due first, and gives a
// wakeup or a message result; the final one has last set. At most sixteen
// results come from one tick, and later due alarms wait for the next tick.
// Alarms with neither flag leave silently. A tick with no result gives one
// none result. Results leave on o_rsp.
// Sequencing: one request at a time. A schedule passes the accept state,
// then the state for the parallel compare and shift insert. A tick passes
// the accept state, the removal of each due alarm in turn, and a closing
// step, popping one front entry per cycle while the output is not stalled.
// A result waits in the output register while o_rsp.ready is low; the
// sequencer then holds, and the next request is accepted once the last
// result of the current one sits in that register.
// Reset clears the alarm count, the id counter and the output valid flag;
// entry storage needs no clearing, so the block is ready right after reset.
module sorted_alarm_timer_queue #(
    parameter int QUEUE_DEPTH = satq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    satq_in_if.sink     i_req,
    satq_out_if.source  o_rsp
);

    satq_pkg::t_cmd    cmd;
    satq_pkg::t_sts    sts;
    satq_pkg::t_item   item;
    satq_pkg::t_result out_data;
    logic              out_valid;
    logic              in_ready;

    // Request fields packed into the form the datapath stores.
    assign item.time_value       = i_req.time_value;
    assign item.process_id       = i_req.process_id;
    assign item.flags            = {i_req.has_message, i_req.is_sleep};
    assign item.queue_descriptor = i_req.queue_descriptor;
    assign item.payload_handle   = i_req.payload_handle;

    satq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_op    (i_req.op),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    satq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_item      (item),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .o_out       (out_data)
    );

    assign i_req.ready        = in_ready;
    assign o_rsp.valid        = out_valid;
    assign o_rsp.kind         = out_data.kind;
    assign o_rsp.alarm_id     = out_data.alarm_id;
    assign o_rsp.owner_id     = out_data.owner_id;
    assign o_rsp.target_queue = out_data.target_queue;
    assign o_rsp.payload_out  = out_data.payload_out;
    assign o_rsp.last         = out_data.last;

endmodule

FILE: hdl/satq_checker.sv
// Port-level checker of the sorted alarm timer queue, bound to the top level.
// Depends on satq_pkg and sorted_alarm_timer_queue_macros.svh.
`include "sorted_alarm_timer_queue_macros.svh"

module satq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [satq_pkg::KIND_W-1:0]   i_kind,
    input logic [satq_pkg::IDENT_W-1:0]  i_alarm_id,
    input logic                          i_last
);

    // A result held by a stalled receiver stays unchanged.
    `SATQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_kind) && $stable(i_alarm_id) && $stable(i_last))

    // Only one request is in work at a time.
    `SATQ_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // Id, rejected and none results are always the only result of a request.
    `SATQ_ASSERT_NOW(a_single_last, i_clk, i_rst_n, i_out_valid && (i_kind == satq_pkg::KIND_ID || i_kind == satq_pkg::KIND_NONE || i_kind == satq_pkg::KIND_FULL), i_last)

    // Kinds beyond the rejected code never appear.
    `SATQ_ASSERT_NOW(a_kind_range, i_clk, i_rst_n, i_out_valid, i_kind <= satq_pkg::KIND_FULL)

endmodule

bind sorted_alarm_timer_queue satq_checker u_satq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_kind      (o_rsp.kind),
    .i_alarm_id  (o_rsp.alarm_id),
    .i_last      (o_rsp.last)
);

FILE: dv/alarm_result_checker.sv
// Result checker for the sorted alarm timer queue: watches both channels,
// predicts the results of every accepted request and compares them in order.
// Depends on satq_pkg, satq_in_if and satq_out_if.
module alarm_result_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    satq_in_if    i_req,
    satq_out_if   i_rsp,
    output int    o_errors,
    output int    o_awaited
);
    timeunit 1ns;
    timeprecision 1ps;
    import satq_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;

    // Pending alarms, kept in the order in which they leave the queue.
    t_entry             alarms [DEPTH];
    int                 alarm_count = 0;
    logic [IDENT_W-1:0] next_alarm_id = '0;
    t_result            awaited_results [$];
    int                 error_count = 0;
    int                 awaited_count = 0;

    assign o_errors  = error_count;
    assign o_awaited = awaited_count;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("result check at %0t ns: %s", $time, what);
    endtask

    // Appends one predicted result behind those already awaited.
    task automatic await_result(input t_result res);
        awaited_results = {awaited_results, res};
    endtask

    // Schedule: sorted insert behind every alarm that is due no later, with
    // ties on due time broken by the lower process id first.
    task automatic predict_schedule(input t_item item);
        t_result id_result;
        int      slot;
        id_result      = '0;
        id_result.last = 1'b1;
        if (alarm_count >= DEPTH) begin
            id_result.kind = KIND_FULL;
            await_result(id_result);
            return;
        end
        slot = alarm_count;
        for (int i = 0; i < alarm_count; i++) begin
            if (item.time_value < alarms[i].due ||
                (item.time_value == alarms[i].due && item.process_id < alarms[i].owner)) begin
                slot = i;
                break;
            end
        end
        for (int i = alarm_count; i > slot; i--) begin
            alarms[i] = alarms[i-1];
        end
        alarms[slot].due     = item.time_value;
        alarms[slot].owner   = item.process_id;
        alarms[slot].flags   = item.flags;
        alarms[slot].queue   = item.queue_descriptor;
        alarms[slot].payload = item.payload_handle;
        alarms[slot].ident   = next_alarm_id;
        alarm_count++;
        id_result.kind     = KIND_ID;
        id_result.alarm_id = next_alarm_id;
        await_result(id_result);
        next_alarm_id = next_alarm_id + 1'b1;
    endtask

    // Tick: pop due alarms from the front. A result is held back by one so
    // that the final one can be marked last before it is queued.
    task automatic predict_tick(input logic [TIME_W-1:0] now);
        t_result held;
        t_result fresh;
        bit      have_held;
        int      popped;
        int      produced;
        have_held = 1'b0;
        held      = '0;
        popped    = 0;
        produced  = 0;
        while (popped < alarm_count && produced < MAX_OUT && alarms[popped].due <= now) begin
            fresh = '0;
            if (alarms[popped].flags != 2'b00) begin
                fresh.alarm_id = alarms[popped].ident;
                fresh.owner_id = alarms[popped].owner;
                // Sleep wins over message; the message is then dropped.
                if (alarms[popped].flags[0]) begin
                    fresh.kind = KIND_WAKE;
                end else begin
                    fresh.kind         = KIND_MSG;
                    fresh.target_queue = alarms[popped].queue;
                    fresh.payload_out  = alarms[popped].payload;
                end
                if (have_held) begin
                    await_result(held);
                end
                held      = fresh;
                have_held = 1'b1;
                produced++;
            end
            popped++;
        end
        for (int i = popped; i < alarm_count; i++) begin
            alarms[i-popped] = alarms[i];
        end
        alarm_count -= popped;
        if (!have_held) begin
            held      = '0;
            held.kind = KIND_NONE;
        end
        held.last = 1'b1;
        await_result(held);
    endtask

    task automatic compare_result();
        t_result want;
        if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result kind %0d id %0d arrived with nothing awaited",
                                      i_rsp.kind, i_rsp.alarm_id));
            return;
        end
        want = awaited_results.pop_front();
        if (i_rsp.kind !== want.kind || i_rsp.alarm_id !== want.alarm_id ||
            i_rsp.owner_id !== want.owner_id || i_rsp.target_queue !== want.target_queue ||
            i_rsp.payload_out !== want.payload_out || i_rsp.last !== want.last) begin
            report_mismatch($sformatf(
                "want k%0d id%0d own%0d q%0d pay%0d l%0b, got k%0d id%0d own%0d q%0d pay%0d l%0b",
                want.kind, want.alarm_id, want.owner_id, want.target_queue,
                want.payload_out, want.last, i_rsp.kind, i_rsp.alarm_id, i_rsp.owner_id,
                i_rsp.target_queue, i_rsp.payload_out, i_rsp.last));
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_item seen;
        if (i_rst_n) begin
            if (i_rsp.valid && i_rsp.ready) begin
                compare_result();
            end
            if (i_req.valid && i_req.ready) begin
                seen.time_value       = i_req.time_value;
                seen.process_id       = i_req.process_id;
                seen.flags            = {i_req.has_message, i_req.is_sleep};
                seen.queue_descriptor = i_req.queue_descriptor;
                seen.payload_handle   = i_req.payload_handle;
                if (i_req.op == OP_SCHED) begin
                    predict_schedule(seen);
                end else begin
                    predict_tick(seen.time_value);
                end
            end
            awaited_count = awaited_results.size();
        end
    end

endmodule

FILE: dv/testbench.sv
// Top of the sorted alarm timer queue testbench: clock, reset, request and
// result stimulus, and the verdict. Depends on satq_pkg, the two channel
// interfaces, the block itself and alarm_result_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import satq_pkg::*;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam int DEPTH_FILL = QUEUE_DEPTH_DEF - 1;

    logic i_clk;
    logic i_rst_n;

    satq_in_if  req_ch ();
    satq_out_if rsp_ch ();

    int failures;
    int results_awaited;

    // Set for the closing part of the run: no gaps between requests and no
    // stalls on the result side.
    bit calm = 1'b0;

    // Running notion of the current time, so that most alarms fall due a
    // little after they are scheduled and most ticks find something to pop.
    logic [TIME_W-1:0] clock_now = 48'd1000;

    sorted_alarm_timer_queue i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    alarm_result_checker result_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .i_rsp     (rsp_ch),
        .o_errors  (failures),
        .o_awaited (results_awaited)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop. The slowest correct run, with every tick giving sixteen
    // results that each wait out a full stall, stays well under a millisecond.
    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    // Result side: ready drops for bursts of random length between stretches
    // of acceptance, and stays high once the run turns calm.
    initial begin
        rsp_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (calm || $urandom_range(0, 2) != 0) begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end
    end

    function automatic t_item alarm(input logic [TIME_W-1:0] due, input logic [PID_W-1:0] pid,
                                    input logic [1:0] flags, input logic [QD_W-1:0] qd,
                                    input logic [PAY_W-1:0] pay);
        t_item item;
        item.time_value       = due;
        item.process_id       = pid;
        item.flags            = flags;
        item.queue_descriptor = qd;
        item.payload_handle   = pay;
        return item;
    endfunction

    function automatic logic [TIME_W-1:0] any_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    // Drives one request and returns at the edge where it is taken. A gap,
    // when one is drawn, lowers valid for a burst of cycles first; otherwise
    // valid stays high straight into the next request.
    task automatic send_request(input logic op, input t_item item);
        if (!calm && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        req_ch.valid            <= 1'b1;
        req_ch.op               <= op;
        req_ch.time_value       <= item.time_value;
        req_ch.process_id       <= item.process_id;
        req_ch.is_sleep         <= item.flags[0];
        req_ch.has_message      <= item.flags[1];
        req_ch.queue_descriptor <= item.queue_descriptor;
        req_ch.payload_handle   <= item.payload_handle;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Directed part: empty tick, field extremes, every flag combination,
    // ties on due time and process id, a silent alarm, a full queue and a
    // tick that drains all sixteen entries at once.
    task automatic run_directed();
        send_request(OP_TICK, alarm('0, '0, 2'b00, '0, '0));
        send_request(OP_SCHED, alarm(TIME_MAX, 16'hFFFF, 2'b11, 16'hFFFF, 16'hFFFF));
        send_request(OP_SCHED, alarm('0, '0, 2'b00, '0, '0));
        send_request(OP_SCHED, alarm(48'd100, 16'd5, 2'b10, 16'hAAAA, 16'h5555));
        send_request(OP_SCHED, alarm(48'd100, 16'd3, 2'b01, 16'h1234, 16'h4321));
        send_request(OP_SCHED, alarm(48'd100, 16'd3, 2'b10, 16'h5555, 16'hAAAA));
        // The silent alarm at time zero leaves without a result.
        send_request(OP_TICK, alarm('0, 16'hFFFF, 2'b11, 16'hFFFF, 16'hFFFF));
        // Three due at once: both pid 3 alarms in arrival order, then pid 5.
        send_request(OP_TICK, alarm(48'd100, '0, 2'b00, '0, '0));
        // Only the far alarm is left; fill the queue up in front of it.
        repeat (DEPTH_FILL) begin
            send_request(OP_SCHED, alarm(48'd200 + $urandom_range(0, 20),
                                         PID_W'($urandom_range(0, 2)),
                                         2'($urandom_range(0, 3)),
                                         QD_W'($urandom_range(0, 65535)),
                                         PAY_W'($urandom_range(0, 65535))));
        end
        send_request(OP_SCHED, alarm(48'd150, 16'd1, 2'b01, 16'h0F0F, 16'hF0F0));
        send_request(OP_TICK, alarm(TIME_MAX, '0, 2'b00, '0, '0));
    endtask

    task automatic run_random(input int count);
        t_item             item;
        logic [TIME_W-1:0] at;
        int                roll;
        for (int n = 0; n < count; n++) begin
            // The last stretch of the run goes without any idling.
            calm = (n >= count - count / 7);
            roll = $urandom_range(0, 99);
            item = alarm('0, PID_W'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)),
                         QD_W'($urandom_range(0, 65535)), PAY_W'($urandom_range(0, 65535)));
            if (roll < 58) begin
                // Schedule: mostly near the current time with a small pool
                // of process ids, so that ties on both keys come up often.
                roll = $urandom_range(0, 99);
                if (roll < 75) at = clock_now + $urandom_range(0, 60);
                else if (roll < 85) at = any_time();
                else if (roll < 95) at = TIME_MAX - $urandom_range(0, 3);
                else at = clock_now - $urandom_range(0, 20);
                item.time_value = at;
                if ($urandom_range(0, 9) < 6) item.process_id = PID_W'($urandom_range(0, 3));
                send_request(OP_SCHED, item);
            end else begin
                // Tick: mostly moves time forward; now and then jumps to a random
                // time, back a little, or to the end of the range to flush the queue.
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    clock_now = clock_now + $urandom_range(0, 40);
                    at = clock_now;
                end else if (roll < 80) at = any_time();
                else if (roll < 90) at = TIME_MAX;
                else at = clock_now - $urandom_range(0, 30);
                item.time_value = at;
                send_request(OP_TICK, item);
            end
        end
    endtask

    initial begin
        i_rst_n                 <= 1'b0;
        req_ch.valid            <= 1'b0;
        req_ch.op               <= OP_SCHED;
        req_ch.time_value       <= '0;
        req_ch.process_id       <= '0;
        req_ch.is_sleep         <= 1'b0;
        req_ch.has_message      <= 1'b0;
        req_ch.queue_descriptor <= '0;
        req_ch.payload_handle   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random(445);
        req_ch.valid <= 1'b0;

        // Drain: wait for every awaited result, then leave room for a tick's
        // worth of cycles in case the block sends anything unexpected.
        do @(posedge i_clk); while (results_awaited != 0);
        repeat (40) @(posedge i_clk);

        if (failures == 0 && results_awaited == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
